// ----- rtl/spsc_pkg.sv -----
package spsc_pkg;

   localparam int MAX_SLABS_DEFAULT   = 4;
   localparam int MAX_CORNERS_DEFAULT = 32;
   localparam int MIN_CORNERS         = 3;
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [1:0] OP_SPAN   = 2'd0;
   localparam logic [1:0] OP_CORNER = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_ZERO_SPAN   = 2'd1;
   localparam logic [1:0] STATUS_FEW_CORNERS = 2'd2;
   localparam logic [1:0] STATUS_RANGE       = 2'd3;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam logic CSR_SLAB_AXIS    = 1'b0;
   localparam logic CSR_SLABS_IN_USE = 1'b1;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_SPAN   = 2'd1,
      KIND_CORNER = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   // span: v0 min, v1 max; corner: v0 a, v1 b; query: v0 along, v1 a, v2 b
   typedef struct packed {
      kind_type           kind;
      logic [1:0]         status;
      logic [1:0]         slab;
      logic [4:0]         corner;
      logic [5:0]         count;
      logic signed [31:0] v0;
      logic signed [31:0] v1;
      logic signed [31:0] v2;
   } item_type;

endpackage

// ----- rtl/spsc_ram.sv -----
module spsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/spsc_front.sv -----
module spsc_front #(
   parameter int MAX_SLABS   = spsc_pkg::MAX_SLABS_DEFAULT,
   parameter int MAX_CORNERS = spsc_pkg::MAX_CORNERS_DEFAULT
) (
   input  logic [1:0]         axis,
   input  logic [1:0]         opcode,
   input  logic [1:0]         slab_index,
   input  logic [4:0]         corner_index,
   input  logic [5:0]         corner_count,
   input  logic signed [31:0] span_low,
   input  logic signed [31:0] span_high,
   input  logic signed [31:0] corner_a,
   input  logic signed [31:0] corner_b,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] point_z,
   output spsc_pkg::item_type item
);

   logic slab_bad;
   logic low_first;

   assign slab_bad  = int'(slab_index) >= MAX_SLABS;
   assign low_first = span_low < span_high;

   always_comb begin
      item        = '0;
      item.kind   = spsc_pkg::KIND_STATUS;
      item.status = spsc_pkg::STATUS_OK;
      item.slab   = slab_index;
      item.corner = corner_index;
      item.count  = corner_count;
      unique case (opcode)
         spsc_pkg::OP_SPAN: begin
            item.v0 = low_first ? span_low : span_high;
            item.v1 = low_first ? span_high : span_low;
            if (slab_bad || int'(corner_count) > MAX_CORNERS) begin
               item.status = spsc_pkg::STATUS_RANGE;
            end else if (span_low == span_high) begin
               item.status = spsc_pkg::STATUS_ZERO_SPAN;
            end else if (int'(corner_count) < spsc_pkg::MIN_CORNERS) begin
               item.status = spsc_pkg::STATUS_FEW_CORNERS;
            end else begin
               item.kind = spsc_pkg::KIND_SPAN;
            end
         end
         spsc_pkg::OP_CORNER: begin
            item.v0 = corner_a;
            item.v1 = corner_b;
            if (slab_bad || int'(corner_index) >= MAX_CORNERS) begin
               item.status = spsc_pkg::STATUS_RANGE;
            end else begin
               item.kind = spsc_pkg::KIND_CORNER;
            end
         end
         spsc_pkg::OP_QUERY: begin
            item.kind = spsc_pkg::KIND_QUERY;
            // transverse coordinates follow the stacking axis cyclically
            case (axis)
               spsc_pkg::AXIS_Y: begin
                  item.v0 = point_y;
                  item.v1 = point_z;
                  item.v2 = point_x;
               end
               spsc_pkg::AXIS_Z: begin
                  item.v0 = point_z;
                  item.v1 = point_x;
                  item.v2 = point_y;
               end
               default: begin
                  item.v0 = point_x;
                  item.v1 = point_y;
                  item.v2 = point_z;
               end
            endcase
         end
         default: begin
            item.status = spsc_pkg::STATUS_RANGE;
         end
      endcase
   end

endmodule

// ----- rtl/spsc_queue.sv -----
module spsc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  spsc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output spsc_pkg::item_type head_item
);

   localparam int PW = $clog2(spsc_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(spsc_pkg::QUEUE_DEPTH + 1);

   spsc_pkg::item_type slot_ff [spsc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = int'(count_ff) == spsc_pkg::QUEUE_DEPTH;
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == spsc_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == spsc_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/spsc_back.sv -----
module spsc_back #(
   parameter int MAX_SLABS   = spsc_pkg::MAX_SLABS_DEFAULT,
   parameter int MAX_CORNERS = spsc_pkg::MAX_CORNERS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [$clog2(MAX_SLABS+1)-1:0]     slabs_used,
   input  logic                               head_valid,
   input  spsc_pkg::item_type                 head_item,
   output logic                               pop,
   output logic                               rsp_strobe,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_point_inside
);

   localparam int SW = $clog2(MAX_SLABS + 1);
   localparam int IW = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
   localparam int AW = $clog2(MAX_SLABS * MAX_CORNERS);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SLAB  = 7'b0000010,
      ST_LOADJ = 7'b0000100,
      ST_EDGE  = 7'b0001000,
      ST_MUL1  = 7'b0010000,
      ST_MUL2  = 7'b0100000,
      ST_CMP   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [31:0] span_min_ff [MAX_SLABS];
   logic signed [31:0] span_max_ff [MAX_SLABS];
   logic [5:0]         count_ff [MAX_SLABS];

   logic signed [31:0] along_ff, along_in;
   logic signed [31:0] pa_ff, pa_in;
   logic signed [31:0] pb_ff, pb_in;
   logic signed [31:0] aj_ff, aj_in;
   logic signed [31:0] bj_ff, bj_in;
   logic signed [32:0] d1_ff, d1_in;
   logic signed [32:0] db_ff, db_in;
   logic signed [32:0] d2_ff, d2_in;
   logic signed [32:0] d3_ff, d3_in;
   logic [63:0]        m1_ff, m1_in;
   logic [63:0]        m2_ff, m2_in;
   logic [SW-1:0]      s_ff, s_in;
   logic [5:0]         n_ff, n_in;
   logic [5:0]         i_ff, i_in;
   logic               inside_ff, inside_in;
   logic               strobe_ff, strobe_in;
   logic [1:0]         status_ff, status_in;
   logic               hit_ff, hit_in;

   logic               span_wr;
   logic [IW-1:0]      wr_slab;
   logic [IW-1:0]      s_idx;
   logic [AW-1:0]      base;
   logic               ram_wr;
   logic [AW-1:0]      ram_wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [63:0]        rd_data;
   logic signed [31:0] ai;
   logic signed [31:0] bi;
   logic [31:0]        mul_x;
   logic [31:0]        mul_y;
   logic [63:0]        prod;
   logic               n1;
   logic               n2;
   logic               c_lt;
   logic               c_gt;
   logic               toggle;
   logic               par;
   logic [5:0]         i_next;

   function automatic logic [31:0] mag(input logic signed [32:0] v);
      logic signed [32:0] r;
      r = v[32] ? -v : v;
      return r[31:0];
   endfunction

   assign wr_slab     = IW'(head_item.slab);
   assign s_idx       = s_ff[IW-1:0];
   assign base        = AW'(int'(s_idx) * MAX_CORNERS);
   assign ram_wr_addr = AW'(int'(head_item.slab) * MAX_CORNERS + int'(head_item.corner));
   assign ai          = rd_data[63:32];
   assign bi          = rd_data[31:0];

   // one shared multiplier, operands picked by state
   assign mul_x = (state_ff == ST_MUL1) ? mag(d1_ff) : mag(d2_ff);
   assign mul_y = (state_ff == ST_MUL1) ? mag(db_ff) : mag(d3_ff);
   assign prod  = {32'd0, mul_x} * {32'd0, mul_y};

   // sign of m1 - m2 with signs, crossing test reversed when db is negative
   always_comb begin
      n1   = (m1_ff != '0) && (d1_ff[32] ^ db_ff[32]);
      n2   = (m2_ff != '0) && (d2_ff[32] ^ d3_ff[32]);
      c_lt = 1'b0;
      c_gt = 1'b0;
      if (n1 != n2) begin
         c_lt = n1;
         c_gt = !n1;
      end else if (m1_ff != m2_ff) begin
         c_lt = n1 ? (m1_ff > m2_ff) : (m1_ff < m2_ff);
         c_gt = !c_lt;
      end
      toggle = db_ff[32] ? c_gt : c_lt;
   end

   assign ram_wr = (state_ff == ST_IDLE) && head_valid && (head_item.kind == spsc_pkg::KIND_CORNER);
   assign span_wr = (state_ff == ST_IDLE) && head_valid && (head_item.kind == spsc_pkg::KIND_SPAN);

   spsc_ram #(
      .WIDTH(64),
      .DEPTH(MAX_SLABS * MAX_CORNERS)
   ) u_corner_ram (
      .clock  (clock),
      .wr_en  (ram_wr),
      .wr_addr(ram_wr_addr),
      .wr_data({head_item.v0, head_item.v1}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in  = state_ff;
      along_in  = along_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      aj_in     = aj_ff;
      bj_in     = bj_ff;
      d1_in     = d1_ff;
      db_in     = db_ff;
      d2_in     = d2_ff;
      d3_in     = d3_ff;
      m1_in     = m1_ff;
      m2_in     = m2_ff;
      s_in      = s_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      inside_in = inside_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      hit_in    = hit_ff;
      pop       = 1'b0;
      rd_addr   = base + AW'(i_ff);
      par       = inside_ff;
      i_next    = i_ff + 6'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop = 1'b1;
               if (head_item.kind == spsc_pkg::KIND_QUERY) begin
                  along_in = head_item.v0;
                  pa_in    = head_item.v1;
                  pb_in    = head_item.v2;
                  s_in     = '0;
                  state_in = ST_SLAB;
               end else begin
                  strobe_in = 1'b1;
                  status_in = head_item.status;
                  hit_in    = 1'b0;
               end
            end
         end
         ST_SLAB: begin
            n_in      = count_ff[s_idx];
            i_in      = '0;
            inside_in = 1'b0;
            rd_addr   = base + AW'(count_ff[s_idx] - 6'd1);
            if (s_ff >= slabs_used) begin
               strobe_in = 1'b1;
               status_in = spsc_pkg::STATUS_OK;
               hit_in    = 1'b0;
               state_in  = ST_IDLE;
            end else if (along_ff < span_min_ff[s_idx] || along_ff > span_max_ff[s_idx] ||
                         int'(count_ff[s_idx]) < spsc_pkg::MIN_CORNERS) begin
               s_in = s_ff + 1'b1;
            end else begin
               state_in = ST_LOADJ;
            end
         end
         ST_LOADJ: begin
            aj_in    = ai;
            bj_in    = bi;
            state_in = ST_EDGE;
         end
         ST_EDGE, ST_CMP: begin
            if (state_ff == ST_EDGE) begin
               d1_in = 33'(pa_ff) - 33'(ai);
               db_in = 33'(bj_ff) - 33'(bi);
               d2_in = 33'(aj_ff) - 33'(ai);
               d3_in = 33'(pb_ff) - 33'(bi);
               aj_in = ai;
               bj_in = bi;
            end else begin
               par = inside_ff ^ toggle;
            end
            if (state_ff == ST_EDGE && ((bi > pb_ff) != (bj_ff > pb_ff))) begin
               state_in = ST_MUL1;
            end else begin
               inside_in = par;
               if (i_next == n_ff) begin
                  if (par) begin
                     strobe_in = 1'b1;
                     status_in = spsc_pkg::STATUS_OK;
                     hit_in    = 1'b1;
                     state_in  = ST_IDLE;
                  end else begin
                     s_in     = s_ff + 1'b1;
                     state_in = ST_SLAB;
                  end
               end else begin
                  i_in     = i_next;
                  rd_addr  = base + AW'(i_next);
                  state_in = ST_EDGE;
               end
            end
         end
         ST_MUL1: begin
            m1_in    = prod;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            m2_in    = prod;
            state_in = ST_CMP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         for (int k = 0; k < MAX_SLABS; k++) begin
            span_min_ff[k] <= '0;
            span_max_ff[k] <= '0;
            count_ff[k]    <= '0;
         end
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         if (span_wr) begin
            span_min_ff[wr_slab] <= head_item.v0;
            span_max_ff[wr_slab] <= head_item.v1;
            count_ff[wr_slab]    <= head_item.count;
         end
      end
      along_ff  <= along_in;
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      aj_ff     <= aj_in;
      bj_ff     <= bj_in;
      d1_ff     <= d1_in;
      db_ff     <= db_in;
      d2_ff     <= d2_in;
      d3_ff     <= d3_in;
      m1_ff     <= m1_in;
      m2_ff     <= m2_in;
      s_ff      <= s_in;
      n_ff      <= n_in;
      i_ff      <= i_in;
      inside_ff <= inside_in;
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_point_inside = hit_ff;

endmodule

// ----- rtl/stacked_polygon_slab_containment.sv -----
// Polygon slab table with point containment queries. Items enter on start while busy is low
// and go through a two-entry queue to the execution side; every item gives exactly one
// result, shown for one cycle on rsp_strobe, which the receiver cannot hold off. Span and
// corner writes are done in the idle state. A query walks the slabs in use in order,
// skipping each whose span misses the point or that holds no polygon, tests each edge of
// the rest and stops at the first slab that holds the point. One 32x32 multiplier is shared
// by the two products of the crossing test on edges that straddle the point, and corners
// come one at a time from the corner memory's single read port. The result beat is
// registered, in the cycle after execution ends. busy rises only when the queue is full.
module stacked_polygon_slab_containment #(
   parameter int MAX_SLABS   = spsc_pkg::MAX_SLABS_DEFAULT,
   parameter int MAX_CORNERS = spsc_pkg::MAX_CORNERS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [1:0]         req_slab_index,
   input  logic [4:0]         req_corner_index,
   input  logic [5:0]         req_corner_count,
   input  logic signed [31:0] req_span_low,
   input  logic signed [31:0] req_span_high,
   input  logic signed [31:0] req_corner_a,
   input  logic signed [31:0] req_corner_b,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic               rsp_point_inside,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [2:0]         csr_data
);

   localparam int SW = $clog2(MAX_SLABS + 1);

   logic [1:0]         slab_axis_ff;
   logic [2:0]         slabs_in_use_ff;
   logic [SW-1:0]      slabs_used;
   logic               full;
   logic               push;
   logic               pop;
   logic               head_valid;
   spsc_pkg::item_type push_item;
   spsc_pkg::item_type head_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         slab_axis_ff    <= '0;
         slabs_in_use_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == spsc_pkg::CSR_SLAB_AXIS) begin
            slab_axis_ff <= csr_data[1:0];
         end else begin
            slabs_in_use_ff <= csr_data;
         end
      end
   end

   assign slabs_used = (int'(slabs_in_use_ff) > MAX_SLABS) ? SW'(MAX_SLABS) : SW'(slabs_in_use_ff);
   assign busy       = full;
   assign push       = start && !full;

   spsc_front #(
      .MAX_SLABS  (MAX_SLABS),
      .MAX_CORNERS(MAX_CORNERS)
   ) u_front (
      .axis        (slab_axis_ff),
      .opcode      (req_opcode),
      .slab_index  (req_slab_index),
      .corner_index(req_corner_index),
      .corner_count(req_corner_count),
      .span_low    (req_span_low),
      .span_high   (req_span_high),
      .corner_a    (req_corner_a),
      .corner_b    (req_corner_b),
      .point_x     (req_point_x),
      .point_y     (req_point_y),
      .point_z     (req_point_z),
      .item        (push_item)
   );

   spsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_item (head_item)
   );

   spsc_back #(
      .MAX_SLABS  (MAX_SLABS),
      .MAX_CORNERS(MAX_CORNERS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .slabs_used      (slabs_used),
      .head_valid      (head_valid),
      .head_item       (head_item),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_point_inside(rsp_point_inside)
   );

endmodule

// ----- verif/tb_stacked_polygon_slab_containment.sv -----
`timescale 1ns / 1ps

module tb_stacked_polygon_slab_containment;

   localparam int SLABS   = spsc_pkg::MAX_SLABS_DEFAULT;
   localparam int CORNERS = spsc_pkg::MAX_CORNERS_DEFAULT;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct {
      logic [1:0]         op;
      logic [1:0]         slab;
      logic [4:0]         corner;
      logic [5:0]         count;
      logic signed [31:0] lo, hi, ca, cb, px, py, pz;
   } req_beat_type;

   typedef struct {
      logic [1:0] status;
      logic       hit;
   } verdict_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_opcode = spsc_pkg::OP_SPAN;
   logic [1:0]         req_slab_index = '0;
   logic [4:0]         req_corner_index = '0;
   logic [5:0]         req_corner_count = '0;
   logic signed [31:0] req_span_low = '0, req_span_high = '0;
   logic signed [31:0] req_corner_a = '0, req_corner_b = '0;
   logic signed [31:0] req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic               rsp_point_inside;
   logic               csr_write = 1'b0;
   logic               csr_index = spsc_pkg::CSR_SLAB_AXIS;
   logic [2:0]         csr_data = '0;

   stacked_polygon_slab_containment uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the slab table
   logic [1:0]         axis_reg;
   logic [2:0]         used_reg;
   logic signed [31:0] span_min[SLABS], span_max[SLABS];
   logic [5:0]         count_mem[SLABS];
   logic signed [31:0] corner_a_mem[SLABS*CORNERS], corner_b_mem[SLABS*CORNERS];
   int                 written_prefix[SLABS];
   bit                 written[SLABS*CORNERS];

   verdict_type verdicts_due[$];
   int          failures = 0;
   int          idle_pct = 0;

   function automatic bit point_in_polygon(int s, logic signed [31:0] a,
                                           logic signed [31:0] b);
      logic signed [67:0] wa, wb, ai, bi, aj, bj, db, lhs, rhs;
      int n, j;
      bit parity;
      n = int'(count_mem[s]);
      parity = 0;
      if (n < spsc_pkg::MIN_CORNERS || n > CORNERS) return 0;
      wa = 68'(a);
      wb = 68'(b);
      j = n - 1;
      for (int i = 0; i < n; i++) begin
         ai = 68'(corner_a_mem[s*CORNERS+i]);
         bi = 68'(corner_b_mem[s*CORNERS+i]);
         aj = 68'(corner_a_mem[s*CORNERS+j]);
         bj = 68'(corner_b_mem[s*CORNERS+j]);
         if ((bi > wb) != (bj > wb)) begin
            db = bj - bi;
            lhs = (wa - ai) * db;
            rhs = (aj - ai) * (wb - bi);
            if ((db > 0 && lhs < rhs) || (db < 0 && lhs > rhs)) parity = !parity;
         end
         j = i;
      end
      return parity;
   endfunction

   function automatic verdict_type apply_beat(req_beat_type t);
      verdict_type v;
      logic signed [31:0] p[3];
      int ax, used, idx, sl;
      v.status = spsc_pkg::STATUS_OK;
      v.hit = 1'b0;
      sl = int'(t.slab);
      case (t.op)
         spsc_pkg::OP_SPAN: begin
            if (sl >= SLABS || int'(t.count) > CORNERS) v.status = spsc_pkg::STATUS_RANGE;
            else if (t.lo == t.hi) v.status = spsc_pkg::STATUS_ZERO_SPAN;
            else if (int'(t.count) < spsc_pkg::MIN_CORNERS) begin
               v.status = spsc_pkg::STATUS_FEW_CORNERS;
            end else begin
               span_min[sl] = (t.lo < t.hi) ? t.lo : t.hi;
               span_max[sl] = (t.lo < t.hi) ? t.hi : t.lo;
               count_mem[sl] = t.count;
            end
         end
         spsc_pkg::OP_CORNER: begin
            if (sl >= SLABS || int'(t.corner) >= CORNERS) v.status = spsc_pkg::STATUS_RANGE;
            else begin
               idx = sl * CORNERS + int'(t.corner);
               corner_a_mem[idx] = t.ca;
               corner_b_mem[idx] = t.cb;
               written[idx] = 1;
               while (written_prefix[sl] < CORNERS &&
                      written[sl*CORNERS + written_prefix[sl]])
                  written_prefix[sl]++;
            end
         end
         spsc_pkg::OP_QUERY: begin
            p[0] = t.px;
            p[1] = t.py;
            p[2] = t.pz;
            ax = int'(axis_reg) % 3;
            used = (int'(used_reg) > SLABS) ? SLABS : int'(used_reg);
            for (int s = 0; s < used && !v.hit; s++) begin
               if (p[ax] < span_min[s] || p[ax] > span_max[s]) continue;
               if (point_in_polygon(s, p[(ax+1)%3], p[(ax+2)%3])) v.hit = 1'b1;
            end
         end
         default: v.status = spsc_pkg::STATUS_RANGE;
      endcase
      return v;
   endfunction

   always @(posedge clock) begin
      verdict_type e;
      if (!reset && rsp_strobe) begin
         if (verdicts_due.size() == 0) begin
            $error("unexpected result beat: status %0d point_inside %0d", rsp_status,
                   rsp_point_inside);
            failures++;
         end else begin
            e = verdicts_due.pop_front();
            if (rsp_status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_status);
               failures++;
            end
            if (rsp_point_inside !== e.hit) begin
               $error("point_inside: expected %0d, got %0d", e.hit, rsp_point_inside);
               failures++;
            end
         end
      end
   end

   // called at a rising edge, returns at a rising edge
   task automatic send_beat(req_beat_type t);
      start <= 1'b1;
      req_opcode <= t.op;
      req_slab_index <= t.slab;
      req_corner_index <= t.corner;
      req_corner_count <= t.count;
      req_span_low <= t.lo;
      req_span_high <= t.hi;
      req_corner_a <= t.ca;
      req_corner_b <= t.cb;
      req_point_x <= t.px;
      req_point_y <= t.py;
      req_point_z <= t.pz;
      do @(posedge clock); while (busy);
      verdicts_due = {verdicts_due, apply_beat(t)};
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [2:0] val);
      drain();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == spsc_pkg::CSR_SLAB_AXIS) axis_reg = val[1:0];
      else used_reg = val;
   endtask

   function automatic req_beat_type blank_beat(logic [1:0] op);
      req_beat_type t;
      t.op = op;
      t.slab = '0;
      t.corner = '0;
      t.count = '0;
      t.lo = '0;
      t.hi = '0;
      t.ca = '0;
      t.cb = '0;
      t.px = '0;
      t.py = '0;
      t.pz = '0;
      return t;
   endfunction

   task automatic put_corner(int s, int c, int a, int b);
      req_beat_type t;
      t = blank_beat(spsc_pkg::OP_CORNER);
      t.slab = 2'(s);
      t.corner = 5'(c);
      t.ca = a;
      t.cb = b;
      send_beat(t);
   endtask

   task automatic put_span(int s, int n, int lo, int hi);
      req_beat_type t;
      t = blank_beat(spsc_pkg::OP_SPAN);
      t.slab = 2'(s);
      t.count = 6'(n);
      t.lo = lo;
      t.hi = hi;
      send_beat(t);
   endtask

   task automatic ask_point(int x, int y, int z);
      req_beat_type t;
      t = blank_beat(spsc_pkg::OP_QUERY);
      t.px = x;
      t.py = y;
      t.pz = z;
      send_beat(t);
   endtask

   function automatic logic signed [31:0] rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $signed($urandom_range(40)) - 20;
      if (r < 92) return ($signed($urandom_range(40)) - 20) * 1024;
      return $urandom;
   endfunction

   task automatic test_directed();
      req_beat_type t;
      write_csr(spsc_pkg::CSR_SLAB_AXIS, {1'b0, spsc_pkg::AXIS_X});
      write_csr(spsc_pkg::CSR_SLABS_IN_USE, 3'd1);
      // 100-by-100 square in slab 0, plus extreme corner values in slab 3
      put_corner(0, 0, 0, 0);
      put_corner(0, 1, 100, 0);
      put_corner(0, 2, 100, 100);
      put_corner(0, 3, 0, 100);
      put_corner(3, 31, 32'sh7fffffff, 32'sh80000000);
      put_corner(3, 30, 32'sh80000000, 32'sh7fffffff);
      ask_point(5, 50, 50);
      put_span(0, 4, 10, -10);
      ask_point(5, 50, 50);
      ask_point(10, 0, 0);
      ask_point(-11, 50, 50);
      ask_point(0, 150, 50);
      ask_point(0, 100, 100);
      ask_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
      put_span(1, 2, 1, 5);
      put_span(1, 5, 7, 7);
      put_span(2, 33, 1, 5);
      put_span(3, 63, 32'sh80000000, 32'sh7fffffff);
      put_span(1, 0, 32'sh80000000, 32'sh7fffffff);
      t = blank_beat(OP_UNKNOWN);
      t.slab = 2'd3;
      t.corner = 5'd31;
      t.count = 6'd63;
      send_beat(t);
      write_csr(spsc_pkg::CSR_SLAB_AXIS, 3'd3);
      write_csr(spsc_pkg::CSR_SLABS_IN_USE, 3'd7);
      ask_point(0, 50, 50);
      write_csr(spsc_pkg::CSR_SLAB_AXIS, {1'b0, spsc_pkg::AXIS_Z});
      ask_point(50, 50, 0);
   endtask

   task automatic test_random(int items);
      req_beat_type t;
      int r, s;
      for (int k = 0; k < items; k++) begin
         t.op = spsc_pkg::OP_QUERY;
         t.slab = 2'($urandom_range(3));
         t.corner = 5'($urandom_range(31));
         t.count = 6'($urandom_range(63));
         t.lo = rand_coord();
         t.hi = rand_coord();
         t.ca = rand_coord();
         t.cb = rand_coord();
         t.px = rand_coord();
         t.py = rand_coord();
         t.pz = rand_coord();
         s = int'(t.slab);
         r = $urandom_range(99);
         if (r < 30) begin
            t.op = spsc_pkg::OP_CORNER;
            if (written_prefix[s] < CORNERS && $urandom_range(1)) begin
               t.corner = 5'(written_prefix[s]);
            end
         end else if (r < 42) begin
            t.op = spsc_pkg::OP_SPAN;
            // good span beats only reference corners already loaded
            if (written_prefix[s] >= spsc_pkg::MIN_CORNERS) begin
               t.count = 6'($urandom_range(spsc_pkg::MIN_CORNERS, (written_prefix[s] > 10 &&
                         $urandom_range(3) != 0) ? 10 : written_prefix[s]));
               if (t.lo == t.hi) t.hi = t.lo + 1;
            end else begin
               t.count = 6'($urandom_range(2));
            end
         end else if (r < 50) begin
            // malformed span beats, unknown opcodes and plain corner writes
            t.op = 2'($urandom_range(3));
            if (t.op == spsc_pkg::OP_QUERY) t.op = OP_UNKNOWN;
            if (t.op == spsc_pkg::OP_SPAN) begin
               case ($urandom_range(2))
                  0: t.count = 6'($urandom_range(CORNERS + 1, 63));
                  1: t.hi = t.lo;
                  default: t.count = 6'($urandom_range(2));
               endcase
            end
         end
         send_beat(t);
      end
   endtask

   initial begin
      logic [2:0] used_set[8] = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd3, 3'd0, 3'd4, 3'd5};
      axis_reg = spsc_pkg::AXIS_X;
      used_reg = '0;
      for (int s = 0; s < SLABS; s++) begin
         span_min[s] = '0;
         span_max[s] = '0;
         count_mem[s] = '0;
         written_prefix[s] = 0;
      end
      for (int i = 0; i < SLABS*CORNERS; i++) begin
         corner_a_mem[i] = '0;
         corner_b_mem[i] = '0;
         written[i] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int ph = 0; ph < 8; ph++) begin
         idle_pct = (ph < 3) ? 38 : (ph < 6) ? 88 : 0;
         write_csr(spsc_pkg::CSR_SLAB_AXIS, 3'(ph % 4));
         write_csr(spsc_pkg::CSR_SLABS_IN_USE, used_set[ph]);
         test_random(178);
      end
      drain();
      repeat (20) @(posedge clock);
      if (failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/spsc_pkg.sv
rtl/spsc_ram.sv
rtl/spsc_front.sv
rtl/spsc_queue.sv
rtl/spsc_back.sv
rtl/stacked_polygon_slab_containment.sv
verif/tb_stacked_polygon_slab_containment.sv
